FILE: design/gmsp_pkg.sv
package gmsp_pkg;

    localparam int SPM_W    = 16;
    localparam int CLK_W    = 29;
    localparam int CFG_W    = 29;
    localparam int POS_W    = 32;
    localparam int TGT_W    = 32;
    localparam int FEED_W   = 25;
    localparam int CNT_W    = 32;
    localparam int FRAC_W   = 10;
    localparam int PROD_W   = TGT_W + SPM_W;
    localparam int RAW_W    = PROD_W - FRAC_W;
    localparam int DVSR_W   = FEED_W - 1 + SPM_W - FRAC_W;
    localparam int DCNT_W   = $clog2(CLK_W);

    localparam logic [SPM_W-1:0] SPM_RESET = 16'd1;
    localparam logic [CLK_W-1:0] CLK_RESET = 29'd180000000;
    localparam logic [CNT_W-1:0] SLOW_LIMIT = 32'd65535;
    localparam logic signed [FEED_W-1:0] FEED_MIN_POS = 25'sd1024;
    localparam logic signed [FEED_W-1:0] FEED_MIN_NEG = -25'sd1024;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

    // configuration register indexes
    localparam logic REG_STEPS_PER_MM = 1'b0;
    localparam logic REG_CLOCK_HZ     = 1'b1;

    typedef enum logic [2:0] {
        CMD_MOVE   = 3'd0,
        CMD_DWELL  = 3'd1,
        CMD_ABS    = 3'd2,
        CMD_REL    = 3'd3,
        CMD_END    = 3'd4,
        CMD_SETPOS = 3'd5,
        CMD_ARC    = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_MOVE      = 3'd0,
        ST_FEED_LOW  = 3'd1,
        ST_FEED_NPOS = 3'd2,
        ST_ZERO      = 3'd3,
        ST_MODE      = 3'd4,
        ST_DWELL     = 3'd5,
        ST_END       = 3'd6,
        ST_IGNORED   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_T,
        S_MUL_F,
        S_PLAN,
        S_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]              status;
        logic                    positive_dir;
        logic [CNT_W-1:0]        step_count;
        logic [CNT_W-1:0]        ticks_per_step;
        logic                    slow_pulses;
        logic [31:0]             dwell_out_ms;
        logic signed [POS_W-1:0] setpoint_steps;
        logic signed [POS_W-1:0] position_steps;
    } result_t;

    function automatic logic signed [POS_W-1:0] sat33(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 33'(POS_MAX))
            r = POS_MAX;
        else if (v < 33'(POS_MIN))
            r = POS_MIN;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat34(input logic signed [POS_W+1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 34'(POS_MAX))
            r = POS_MAX;
        else if (v < 34'(POS_MIN))
            r = POS_MIN;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

FILE: design/gmsp_cmd_if.sv
interface gmsp_cmd_if
    import gmsp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [2:0]               command;
    logic signed [TGT_W-1:0]  target_mm;
    logic signed [FEED_W-1:0] feed_mm_s;
    logic [31:0]              dwell_ms;
    logic signed [POS_W-1:0]  new_position;

    modport source (output valid, command, target_mm, feed_mm_s, dwell_ms, new_position,
                    input ready);
    modport sink (input valid, command, target_mm, feed_mm_s, dwell_ms, new_position,
                  output ready);
endinterface

FILE: design/gmsp_res_if.sv
interface gmsp_res_if
    import gmsp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic                    positive_dir;
    logic [CNT_W-1:0]        step_count;
    logic [CNT_W-1:0]        ticks_per_step;
    logic                    slow_pulses;
    logic [31:0]             dwell_out_ms;
    logic signed [POS_W-1:0] setpoint_steps;
    logic signed [POS_W-1:0] position_steps;

    modport source (output valid, status, positive_dir, step_count, ticks_per_step,
                    slow_pulses, dwell_out_ms, setpoint_steps, position_steps,
                    input ready);
    modport sink (input valid, status, positive_dir, step_count, ticks_per_step,
                  slow_pulses, dwell_out_ms, setpoint_steps, position_steps,
                  output ready);
endinterface

FILE: design/gcode_move_to_step_pulse_plan.sv
// Sequence: an issued move runs decode, two multiplies, plan, one divider iteration per
// quotient bit, then finish; a move rejected at plan (feed not positive, zero steps) skips
// the divider, and a move with feed under 1 mm/s and all other commands go decode to finish.
// A new command is taken only once the last one has left finish; a result still held
// back in the output slot stalls finish.
// Reset: setpoint, position and mode clear to zero/absolute, config regs load defaults.
module gcode_move_to_step_pulse_plan
    import gmsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    gmsp_cmd_if.sink         cmd,
    gmsp_res_if.source       res
);

    // sequencer
    state_t state_reg, state_next;

    // latched command
    logic [2:0]               cmd_reg, cmd_next;
    logic signed [TGT_W-1:0]  tgt_reg, tgt_next;
    logic signed [FEED_W-1:0] feed_reg, feed_next;
    logic [31:0]              dwell_reg, dwell_next;
    logic signed [POS_W-1:0]  newpos_reg, newpos_next;

    // configuration
    logic [SPM_W-1:0] spm_reg, spm_next;
    logic [CLK_W-1:0] clk_hz_reg, clk_hz_next;

    // axis state
    logic signed [POS_W-1:0] sp_reg, sp_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    rel_reg, rel_next;

    // shared multiplier result and move scratch
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [POS_W-1:0] steps_reg, steps_next;

    // divider: quo_reg starts as the dividend and shifts into the quotient
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [CLK_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    // result being built, and the output slot
    result_t pend_reg, pend_next;
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    // multiplier operands: target magnitude, then feed magnitude
    logic [TGT_W-1:0]  tgt_mag;
    logic [FEED_W-1:0] feed_mag;
    logic [TGT_W-1:0]  mul_a;
    logic [PROD_W-1:0] mul_p;

    // plan arithmetic
    logic [RAW_W-1:0]        raw;
    logic signed [POS_W-1:0] steps_sat;
    logic [DVSR_W-1:0]       fsteps;
    logic                    feed_bad;
    logic signed [POS_W:0]   delta;
    logic [POS_W:0]          delta_mag;
    logic signed [POS_W+1:0] pos_sum;

    // divider step
    logic [DVSR_W:0] trial;
    logic            ge;

    logic [CNT_W-1:0] ticks;

    assign tgt_mag  = tgt_reg[TGT_W-1] ? TGT_W'(0) - tgt_reg : tgt_reg;
    assign feed_mag = feed_reg[FEED_W-1] ? FEED_W'(0) - feed_reg : feed_reg;
    assign mul_a    = (state_reg == S_MUL_T) ? tgt_mag : TGT_W'(feed_mag);
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(spm_reg);

    // target steps: truncate toward zero, then saturate to 32-bit signed
    assign raw = prod_reg[PROD_W-1:FRAC_W];
    always_comb
    begin
        if (!tgt_reg[TGT_W-1])
            steps_sat = (raw > RAW_W'(POS_MAX)) ? POS_MAX : raw[POS_W-1:0];
        else
            steps_sat = (raw > RAW_W'(33'h080000000)) ? POS_MIN
                                                       : POS_W'(0) - raw[POS_W-1:0];
    end

    // feed steps (second product); non-positive when feed negative or spm zero
    assign fsteps    = prod_reg[FRAC_W +: DVSR_W];
    assign feed_bad  = feed_reg[FEED_W-1] || (fsteps == '0);
    assign delta     = rel_reg ? (POS_W+1)'(steps_reg)
                               : (POS_W+1)'(steps_reg) - (POS_W+1)'(pos_reg);
    assign delta_mag = delta[POS_W] ? (POS_W+1)'(0) - delta : delta;
    assign pos_sum   = (POS_W+2)'(pos_reg) + (POS_W+2)'(delta);

    assign trial = {rem_reg, quo_reg[CLK_W-1]};
    assign ge    = trial >= {1'b0, dvsr_reg};
    assign ticks = CNT_W'(quo_reg);

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.status         = out_reg.status;
    assign res.positive_dir   = out_reg.positive_dir;
    assign res.step_count     = out_reg.step_count;
    assign res.ticks_per_step = out_reg.ticks_per_step;
    assign res.slow_pulses    = out_reg.slow_pulses;
    assign res.dwell_out_ms   = out_reg.dwell_out_ms;
    assign res.setpoint_steps = out_reg.setpoint_steps;
    assign res.position_steps = out_reg.position_steps;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        tgt_next       = tgt_reg;
        feed_next      = feed_reg;
        dwell_next     = dwell_reg;
        newpos_next    = newpos_reg;
        spm_next       = spm_reg;
        clk_hz_next    = clk_hz_reg;
        sp_next        = sp_reg;
        pos_next       = pos_reg;
        rel_next       = rel_reg;
        prod_next      = prod_reg;
        steps_next     = steps_reg;
        dvsr_next      = dvsr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // config writes are expected only while no command is in flight
        if (cfg_we)
        begin
            case (cfg_index)
                REG_STEPS_PER_MM: spm_next    = cfg_data[SPM_W-1:0];
                REG_CLOCK_HZ:     clk_hz_next = cfg_data[CLK_W-1:0];
                default:          ;
            endcase
        end

        if (res.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next    = cmd.command;
                    tgt_next    = cmd.target_mm;
                    feed_next   = cmd.feed_mm_s;
                    dwell_next  = cmd.dwell_ms;
                    newpos_next = cmd.new_position;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                pend_next  = '0;
                quo_next   = '0;
                state_next = S_FINISH;
                case (cmd_t'(cmd_reg))
                    CMD_MOVE:
                    begin
                        if (feed_reg > FEED_MIN_NEG && feed_reg < FEED_MIN_POS)
                            pend_next.status = ST_FEED_LOW;
                        else
                            state_next = S_MUL_T;
                    end
                    CMD_DWELL:
                    begin
                        pend_next.status       = ST_DWELL;
                        pend_next.dwell_out_ms = dwell_reg;
                    end
                    CMD_ABS:
                    begin
                        rel_next         = 1'b0;
                        pend_next.status = ST_MODE;
                    end
                    CMD_REL:
                    begin
                        rel_next         = 1'b1;
                        pend_next.status = ST_MODE;
                    end
                    CMD_END:
                        pend_next.status = ST_END;
                    CMD_SETPOS:
                    begin
                        sp_next          = newpos_reg;
                        pos_next         = newpos_reg;
                        pend_next.status = ST_MODE;
                    end
                    default:
                        pend_next.status = ST_IGNORED;
                endcase
            end

            S_MUL_T:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_F;
            end

            S_MUL_F:
            begin
                steps_next = steps_sat;
                prod_next  = mul_p;
                state_next = S_PLAN;
            end

            S_PLAN:
            begin
                sp_next = rel_reg ? sat33((POS_W+1)'(sp_reg) + (POS_W+1)'(steps_reg))
                                  : steps_reg;
                pend_next.positive_dir = !delta[POS_W] && (delta != '0);
                pend_next.step_count   = delta_mag[CNT_W-1:0];
                state_next             = S_FINISH;
                if (feed_bad)
                    pend_next.status = ST_FEED_NPOS;
                else if (delta == '0)
                begin
                    pend_next.status       = ST_ZERO;
                    pend_next.positive_dir = 1'b0;
                end
                else
                begin
                    pend_next.status = ST_MOVE;
                    pos_next         = sat34(pos_sum);
                    dvsr_next        = fsteps;
                    rem_next         = '0;
                    quo_next         = clk_hz_reg;
                    dcnt_next        = '0;
                    state_next       = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next  = ge ? DVSR_W'(trial - {1'b0, dvsr_reg}) : trial[DVSR_W-1:0];
                quo_next  = {quo_reg[CLK_W-2:0], ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(CLK_W - 1))
                    state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next                = pend_reg;
                    out_next.ticks_per_step = ticks;
                    out_next.slow_pulses    = ticks > SLOW_LIMIT;
                    out_next.setpoint_steps = sp_reg;
                    out_next.position_steps = pos_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            spm_reg       <= SPM_RESET;
            clk_hz_reg    <= CLK_RESET;
            sp_reg        <= '0;
            pos_reg       <= '0;
            rel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            spm_reg       <= spm_next;
            clk_hz_reg    <= clk_hz_next;
            sp_reg        <= sp_next;
            pos_reg       <= pos_next;
            rel_reg       <= rel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        tgt_reg    <= tgt_next;
        feed_reg   <= feed_next;
        dwell_reg  <= dwell_next;
        newpos_reg <= newpos_next;
        prod_reg   <= prod_next;
        steps_reg  <= steps_next;
        dvsr_reg   <= dvsr_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dcnt_reg   <= dcnt_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

endmodule

FILE: design/gmsp_checker.sv
module gmsp_checker
    import gmsp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [2:0]       status,
    input logic [CNT_W-1:0] step_count,
    input logic [CNT_W-1:0] ticks_per_step,
    input logic             slow_pulses,
    input logic [31:0]      dwell_out_ms
);

    // one command in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> slow_pulses == (ticks_per_step > SLOW_LIMIT))
    else $error("slow pulse flag disagrees with ticks");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_MOVE |-> step_count != '0)
    else $error("move issued with zero steps");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dwell_out_ms != '0 |-> status == ST_DWELL)
    else $error("dwell length on a non-dwell result");

endmodule

bind gcode_move_to_step_pulse_plan gmsp_checker u_gmsp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (cmd.valid),
    .in_ready       (cmd.ready),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .status         (res.status),
    .step_count     (res.step_count),
    .ticks_per_step (res.ticks_per_step),
    .slow_pulses    (res.slow_pulses),
    .dwell_out_ms   (res.dwell_out_ms)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gmsp_pkg::*;

    // Code 7 is not in the command enum but the block must answer it as ignored
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam int CYCLE_LIMIT = 600000;
    // settle time after the last result is taken, longer than a move takes
    localparam int SETTLE_CYCLES = 40;
    // receiver hold-off for the back-pressure phase
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 75;
    localparam int NUM_PHASES = 10;

    typedef struct {
        logic [2:0]               command;
        logic signed [TGT_W-1:0]  target_mm;
        logic signed [FEED_W-1:0] feed_mm_s;
        logic [31:0]              dwell_ms;
        logic signed [POS_W-1:0]  new_position;
    } cmd_item_t;

    // Planner state mirror plus the queue of results still owed by the block.
    class plan_book;
        result_t                 owed[$];
        logic [SPM_W-1:0]        spm;
        logic [CLK_W-1:0]        hz;
        logic signed [POS_W-1:0] setpoint;
        logic signed [POS_W-1:0] position;
        bit                      relative;
        int                      mismatches;
        int                      results_seen;

        function new();
            spm = SPM_RESET;
            hz = CLK_RESET;
            setpoint = '0;
            position = '0;
            relative = 1'b0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_STEPS_PER_MM)
                spm = val[SPM_W-1:0];
            else
                hz = val[CLK_W-1:0];
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // 1/1024 mm units to steps, truncated toward zero
        function longint to_steps(longint a);
            longint m;
            m = (a < 0) ? -a : a;
            m = (m * longint'(spm)) >>> FRAC_W;
            return (a < 0) ? -m : m;
        endfunction

        function logic signed [POS_W-1:0] clamp_pos(longint v);
            if (v > longint'(POS_MAX))
                return POS_MAX;
            if (v < longint'(POS_MIN))
                return POS_MIN;
            return v[POS_W-1:0];
        endfunction

        function void note_command(cmd_item_t it);
            result_t r;
            longint  feed;
            longint  steps;
            longint  fsteps;
            longint  delta;
            longint  mag;
            longint  ticks;
            r = '0;
            feed = it.feed_mm_s;
            case (it.command)
                CMD_MOVE:
                begin
                    if (feed > longint'(FEED_MIN_NEG) && feed < longint'(FEED_MIN_POS))
                    begin
                        // feed under 1 mm/s: nothing moves, state untouched
                        r.status = ST_FEED_LOW;
                    end
                    else
                    begin
                        steps = clamp_pos(to_steps(longint'(it.target_mm)));
                        fsteps = to_steps(feed);
                        if (relative)
                        begin
                            delta = steps;
                            setpoint = clamp_pos(longint'(setpoint) + steps);
                        end
                        else
                        begin
                            setpoint = clamp_pos(steps);
                            delta = steps - longint'(position);
                        end
                        r.positive_dir = (delta > 0);
                        mag = (delta < 0) ? -delta : delta;
                        if (fsteps <= 0)
                        begin
                            // setpoint already moved, position stays
                            r.status = ST_FEED_NPOS;
                            r.step_count = mag[CNT_W-1:0];
                        end
                        else if (mag == 0)
                        begin
                            r.status = ST_ZERO;
                            r.positive_dir = 1'b0;
                        end
                        else
                        begin
                            r.status = ST_MOVE;
                            r.step_count = mag[CNT_W-1:0];
                            ticks = longint'(hz) / fsteps;
                            r.ticks_per_step = ticks[CNT_W-1:0];
                            r.slow_pulses = (ticks > longint'(SLOW_LIMIT));
                            position = clamp_pos(longint'(position) + delta);
                        end
                    end
                end
                CMD_DWELL:
                begin
                    r.status = ST_DWELL;
                    r.dwell_out_ms = it.dwell_ms;
                end
                CMD_ABS:
                begin
                    relative = 1'b0;
                    r.status = ST_MODE;
                end
                CMD_REL:
                begin
                    relative = 1'b1;
                    r.status = ST_MODE;
                end
                CMD_END:
                    r.status = ST_END;
                CMD_SETPOS:
                begin
                    position = it.new_position;
                    setpoint = it.new_position;
                    r.status = ST_MODE;
                end
                default:
                    r.status = ST_IGNORED;
            endcase
            r.setpoint_steps = setpoint;
            r.position_steps = position;
            owed.push_back(r);
        endfunction

        function void show(string tag, result_t r);
            $display("  %s: status=%0d dir=%0b count=%0d ticks=%0d slow=%0b dwell=%0d sp=%0d pos=%0d",
                     tag, r.status, r.positive_dir, r.step_count, r.ticks_per_step,
                     r.slow_pulses, r.dwell_out_ms, $signed(r.setpoint_steps),
                     $signed(r.position_steps));
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d arrived with nothing owed", results_seen);
                    show("actual", got);
                end
                return;
            end
            want = owed.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d mismatch", results_seen);
                    show("expected", want);
                    show("actual", got);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    gmsp_cmd_if cmd_ch();
    gmsp_res_if res_ch();

    gcode_move_to_step_pulse_plan uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    plan_book book;

    // idle controls for the command driver and the result receiver
    bit sender_no_idle;
    bit receiver_no_idle;
    bit hold_off_request;
    int cycle_count;

    // reused by the random commands so absolute moves often land on zero steps
    logic signed [TGT_W-1:0] last_target;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly no gap, often a short one, a few long ones.
    function automatic int idle_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic cmd_item_t mk_cmd(logic [2:0] c, logic signed [TGT_W-1:0] t,
                                         logic signed [FEED_W-1:0] f, logic [31:0] d,
                                         logic signed [POS_W-1:0] np);
        cmd_item_t it;
        it.command = c;
        it.target_mm = t;
        it.feed_mm_s = f;
        it.dwell_ms = d;
        it.new_position = np;
        return it;
    endfunction

    // Random command: mostly moves with usable feed, some mode changes and
    // position loads to steer the state, and a share of rejected and noise items.
    function automatic cmd_item_t random_cmd();
        cmd_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            it.command = CMD_MOVE;
        else if (r < 62)
            it.command = CMD_DWELL;
        else if (r < 70)
            it.command = CMD_ABS;
        else if (r < 78)
            it.command = CMD_REL;
        else if (r < 83)
            it.command = CMD_END;
        else if (r < 90)
            it.command = CMD_SETPOS;
        else if (r < 95)
            it.command = CMD_ARC;
        else
            it.command = CMD_UNUSED;

        r = $urandom_range(0, 99);
        if (r < 40)
            it.target_mm = int'($urandom_range(0, 400000)) - 200000;
        else if (r < 60)
            it.target_mm = $urandom;
        else if (r < 70)
        begin
            case ($urandom_range(0, 4))
                0: it.target_mm = POS_MAX;
                1: it.target_mm = POS_MIN;
                2: it.target_mm = 0;
                3: it.target_mm = -1;
                default: it.target_mm = 1;
            endcase
        end
        else if (r < 85)
            it.target_mm = last_target;
        else
            it.target_mm = int'($urandom_range(0, 1 << 25)) - (1 << 24);

        r = $urandom_range(0, 99);
        if (r < 45)
            it.feed_mm_s = FEED_W'($urandom_range(1024, 200000));
        else if (r < 60)
            it.feed_mm_s = FEED_W'($urandom_range(1024, 24'hFFFFFF));
        else if (r < 72)
            it.feed_mm_s = FEED_W'(int'($urandom_range(0, 2046)) - 1023);
        else if (r < 82)
            it.feed_mm_s = FEED_W'(-int'($urandom_range(1024, 1 << 24)));
        else
            it.feed_mm_s = FEED_W'($urandom);

        it.dwell_ms = $urandom;
        if ($urandom_range(0, 1) == 0)
            it.new_position = int'($urandom_range(0, 200000)) - 100000;
        else
            it.new_position = $urandom;

        if (it.command == CMD_MOVE)
            last_target = it.target_mm;
        return it;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happened,
    // leaving valid high so a back-to-back item needs no extra edge.
    task automatic send_command(cmd_item_t it);
        int gap;
        bit hit;
        gap = idle_gap(sender_no_idle);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= it.command;
        cmd_ch.target_mm <= it.target_mm;
        cmd_ch.feed_mm_s <= it.feed_mm_s;
        cmd_ch.dwell_ms <= it.dwell_ms;
        cmd_ch.new_position <= it.new_position;
        // ready is stable mid-cycle; sample it there to stay clear of edge races
        do
        begin
            @(negedge clk);
            hit = cmd_ch.ready;
            @(posedge clk);
        end
        while (!hit);
        book.note_command(it);
    endtask

    // Every command owes exactly one result, so an empty queue means idle.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.set_register(idx, val);
        @(posedge clk);
    endtask

    task automatic set_rates(logic [SPM_W-1:0] spm, logic [CLK_W-1:0] hz);
        write_register(REG_STEPS_PER_MM, CFG_W'(spm));
        write_register(REG_CLOCK_HZ, CFG_W'(hz));
    endtask

    // Result side: random ready pattern, plus one long hold-off on request.
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else
            begin
                int busy;
                int gap;
                busy = $urandom_range(1, 12);
                gap = idle_gap(receiver_no_idle);
                res_ch.ready <= 1'b1;
                repeat (busy) @(posedge clk);
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    // Result transfers, sampled mid-cycle before the edge that completes them.
    always @(negedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.status = res_ch.status;
            got.positive_dir = res_ch.positive_dir;
            got.step_count = res_ch.step_count;
            got.ticks_per_step = res_ch.ticks_per_step;
            got.slow_pulses = res_ch.slow_pulses;
            got.dwell_out_ms = res_ch.dwell_out_ms;
            got.setpoint_steps = res_ch.setpoint_steps;
            got.position_steps = res_ch.position_steps;
            book.check_result(got);
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [SPM_W-1:0] spm;
        logic [CLK_W-1:0] hz;

        book = new();
        sender_no_idle = 1'b0;
        receiver_no_idle = 1'b0;
        hold_off_request = 1'b0;
        last_target = '0;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_STEPS_PER_MM;
        cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= CMD_END;
        cmd_ch.target_mm <= '0;
        cmd_ch.feed_mm_s <= '0;
        cmd_ch.dwell_ms <= '0;
        cmd_ch.new_position <= '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset rates: 1 step/mm, 180 MHz.
        // zero steps from the origin
        send_command(mk_cmd(CMD_MOVE, 0, 1024, 0, 0));
        // feed just under 1 mm/s either way
        send_command(mk_cmd(CMD_MOVE, 102400, 1023, 0, 0));
        send_command(mk_cmd(CMD_MOVE, 102400, -1023, 0, 0));
        // negative feed: setpoint moves, position does not
        send_command(mk_cmd(CMD_MOVE, 102400, -1024, 0, 0));
        // slowest legal feed, huge tick count
        send_command(mk_cmd(CMD_MOVE, 102400, 1024, 0, 0));
        send_command(mk_cmd(CMD_MOVE, POS_MAX, 25'sh0FFFFFF, 32'hFFFFFFFF, POS_MAX));
        send_command(mk_cmd(CMD_MOVE, POS_MIN, 25'sh1000000, 0, POS_MIN));
        send_command(mk_cmd(CMD_DWELL, -1, -1, 32'hFFFFFFFF, -1));
        send_command(mk_cmd(CMD_DWELL, 0, 0, 0, 0));
        send_command(mk_cmd(CMD_END, 5, 5000, 5, 5));
        send_command(mk_cmd(CMD_ARC, 102400, 4096, 7, 9));
        send_command(mk_cmd(CMD_UNUSED, 102400, 4096, 7, 9));
        send_command(mk_cmd(CMD_SETPOS, 0, 0, 0, -5));
        send_command(mk_cmd(CMD_REL, 0, 0, 0, 0));
        send_command(mk_cmd(CMD_MOVE, -10240, 2048, 0, 0));
        send_command(mk_cmd(CMD_ABS, 0, 0, 0, 0));
        drain_results();

        // Largest scale and clock: target saturates, relative sums saturate,
        // fastest feed drives ticks to zero.
        set_rates(16'hFFFF, 29'd400000000);
        send_command(mk_cmd(CMD_MOVE, POS_MAX, 1024, 0, 0));
        send_command(mk_cmd(CMD_MOVE, POS_MIN, 25'sh0FFFFFF, 0, 0));
        send_command(mk_cmd(CMD_SETPOS, 0, 0, 0, POS_MAX));
        send_command(mk_cmd(CMD_REL, 0, 0, 0, 0));
        send_command(mk_cmd(CMD_MOVE, POS_MAX, 1024, 0, 0));
        send_command(mk_cmd(CMD_ABS, 0, 0, 0, 0));
        drain_results();

        // zero scale: every feed converts to zero steps per second
        set_rates(16'd0, 29'd0);
        send_command(mk_cmd(CMD_MOVE, 102400, 4096, 0, 0));
        drain_results();
        // zero clock: ticks per step comes out zero
        set_rates(16'd1, 29'd0);
        send_command(mk_cmd(CMD_MOVE, 204800, 4096, 0, 0));
        send_command(mk_cmd(CMD_SETPOS, 0, 0, 0, 0));
        drain_results();

        // Random phases, each with its own rates.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            spm = SPM_W'($urandom_range(1, 65535));
            hz = CLK_W'($urandom_range(1, 400000000));
            case (p)
                0:
                begin
                    spm = SPM_RESET;
                    hz = CLK_RESET;
                end
                1:
                begin
                    spm = 16'hFFFF;
                    hz = 29'd400000000;
                end
                2:
                begin
                    spm = 16'd1;
                    hz = 29'd1;
                end
                3:
                begin
                    spm = 16'd800;
                    hz = 29'd180000000;
                end
                5:
                begin
                    spm = 16'hFFFF;
                    hz = 29'd1;
                end
                7:
                begin
                    spm = 16'd16;
                    hz = 29'd400000000;
                end
                8:
                    hz = CLK_W'($urandom_range(1, 100000));
                default:
                    ;
            endcase
            set_rates(spm, hz);

            // phase 3: receiver stalls long while commands keep coming;
            // phase 5: no idling on either side
            sender_no_idle = (p == 3 || p == 5);
            receiver_no_idle = (p == 5);
            if (p == 3)
                hold_off_request = 1'b1;

            repeat (PHASE_ITEMS) send_command(random_cmd());
            drain_results();
            sender_no_idle = 1'b0;
            receiver_no_idle = 1'b0;
        end

        if (book.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
